@@ design/cstc_pkg.sv @@
// Shared types, constants and character-class functions for the token classifier.
package cstc_pkg;

	// Default sizes; the top level hands them down as parameters.
	localparam int MAX_TOKEN_LEN_DEF = 63;
	localparam int KEYWORD_CHARS_DEF = 6;
	localparam int QUEUE_DEPTH_DEF   = 4;

	// Keyword table, in the order reported by keyword_index.
	localparam int KW_COUNT   = 10;
	localparam int KW_MAX_LEN = 6;
	localparam logic [3:0] NO_KEYWORD = 4'd10;

	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00},
		'{"f", "l", "o", "a", "t", 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00},
		'{"r", "e", "t", "u", "r", "n"},
		'{"f", "o", "r", 8'h00, 8'h00, 8'h00},
		'{"c", "h", "a", "r", 8'h00, 8'h00},
		'{"d", "o", "u", "b", "l", "e"},
		'{"v", "o", "i", "d", 8'h00, 8'h00}
	};
	localparam int KW_LEN [KW_COUNT] = '{3, 5, 2, 4, 5, 6, 3, 4, 6, 4};

	// Characters with a special meaning to the scanner.
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	// Token kinds as they appear on the output.
	typedef enum logic [2:0] {
		KIND_KEYWORD   = 3'd0,
		KIND_IDENT     = 3'd1,
		KIND_NUMBER    = 3'd2,
		KIND_OPERATOR  = 3'd3,
		KIND_SEPARATOR = 3'd4,
		KIND_UNKNOWN   = 3'd5,
		KIND_COMMENT   = 3'd6
	} token_kind_t;

	// Scanner modes, one-hot.
	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_WORD    = 5'b00010,
		MODE_NUMBER  = 5'b00100,
		MODE_SLASH   = 5'b01000,
		MODE_COMMENT = 5'b10000
	} scan_mode_t;

	// One output token.
	typedef struct packed {
		token_kind_t kind;
		logic [7:0]  symbol;
		logic [5:0]  length;
		logic [3:0]  kw_index;
	} token_t;

	// Everything one input byte produces: one token, or two when a pending word,
	// number or slash ends and the ending byte is itself a token.
	typedef struct packed {
		logic   two;
		token_t tok0;
		token_t tok1;
	} tok_rec_t;

	// Push side of the queue between the front and the back.
	typedef struct packed {
		logic     push;
		tok_rec_t rec;
	} push_req_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {["a":"z"]}) || (c inside {["A":"Z"]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || (c inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic is_oper(input logic [7:0] c);
		return c inside {"+", "-", "*", "=", "<", ">"};
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		return c inside {";", ",", "(", ")", "{", "}"};
	endfunction

endpackage

@@ design/cstc_char_if.sv @@
// Input channel: one character word per handshake.
interface cstc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_input;

	modport source (output valid, output char_in, output end_of_input, input ready);
	modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

@@ design/cstc_token_if.sv @@
// Output channel: one token word per handshake.
interface cstc_token_if;
	logic       valid;
	logic       ready;
	logic [2:0] token_kind;
	logic [7:0] symbol;
	logic [5:0] token_length;
	logic [3:0] keyword_index;
	logic       last_result;

	modport source (output valid, output token_kind, output symbol, output token_length,
		output keyword_index, output last_result, input ready);
	modport sink (input valid, input token_kind, input symbol, input token_length,
		input keyword_index, input last_result, output ready);
endinterface

@@ design/cstc_front.sv @@
// Scanner front end: takes one character a cycle while the queue is not full,
// tracks the pending word and classifies tokens into records for the queue.
module cstc_front import cstc_pkg::*; #(
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
	parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cstc_char_if.sink char_chan,
	input  logic      q_full,
	output push_req_t push_req
);

	localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

	scan_mode_t    mode_q, mode_d, start_mode;
	logic [LW-1:0] len_q, len_d, len_grow, chars_idx;
	logic [7:0]    chars_q [KEYWORD_CHARS];
	logic [7:0]    c;
	logic          accept, c_alnum, chars_we;
	logic          flush_vld, start_vld, use_flush, use_start, restart, add;
	token_t        flush_tok, start_tok;
	logic [KW_COUNT-1:0] kw_hit;
	logic [3:0]    kw_idx;

	assign c                = char_chan.char_in;
	assign c_alnum          = is_alpha(c) || is_digit(c);
	assign char_chan.ready  = !q_full;
	assign accept           = char_chan.valid && !q_full;

	// Keyword compare: all ten entries in parallel, lowest index wins.
	always_comb begin
		for (int i = 0; i < KW_COUNT; i++) begin
			kw_hit[i] = (len_q == LW'(KW_LEN[i]));
			for (int j = 0; j < KW_MAX_LEN; j++) begin
				if (j < KW_LEN[i] && chars_q[j] != KW_TEXT[i][j]) begin
					kw_hit[i] = 1'b0;
				end
			end
		end
		kw_idx = NO_KEYWORD;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (kw_hit[i]) begin
				kw_idx = 4'(i);
			end
		end
	end

	// Token for whatever is pending in the current mode.
	always_comb begin
		flush_tok = '{kind: KIND_OPERATOR, symbol: 8'h00, length: 6'd0, kw_index: NO_KEYWORD};
		flush_vld = 1'b1;
		case (mode_q)
			MODE_WORD: begin
				flush_tok.kind     = (kw_idx == NO_KEYWORD) ? KIND_IDENT : KIND_KEYWORD;
				flush_tok.length   = 6'(len_q);
				flush_tok.kw_index = kw_idx;
			end
			MODE_NUMBER: begin
				flush_tok.kind   = KIND_NUMBER;
				flush_tok.length = 6'(len_q);
			end
			MODE_SLASH: begin
				flush_tok.symbol = CH_SLASH;
			end
			MODE_COMMENT: begin
				flush_tok.kind = KIND_COMMENT;
			end
			default: begin
				flush_vld = 1'b0;
			end
		endcase
	end

	// Classification of a character seen with nothing pending.
	always_comb begin
		start_tok  = '{kind: KIND_UNKNOWN, symbol: c, length: 6'd0, kw_index: NO_KEYWORD};
		start_vld  = 1'b0;
		start_mode = MODE_IDLE;
		if (is_alpha(c)) begin
			start_mode = MODE_WORD;
		end else if (is_digit(c)) begin
			start_mode = MODE_NUMBER;
		end else if (c == CH_SLASH) begin
			start_mode = MODE_SLASH;
		end else if (!is_space(c)) begin
			start_vld = 1'b1;
			if (is_oper(c)) begin
				start_tok.kind = KIND_OPERATOR;
			end else if (is_sep(c)) begin
				start_tok.kind = KIND_SEPARATOR;
			end
		end
	end

	assign len_grow = (int'(len_q) < MAX_TOKEN_LEN) ? len_q + LW'(1) : len_q;

	// Mode transitions.
	always_comb begin
		mode_d    = mode_q;
		len_d     = len_q;
		use_flush = 1'b0;
		use_start = 1'b0;
		restart   = 1'b0;
		add       = 1'b0;
		if (char_chan.end_of_input) begin
			use_flush = flush_vld;
			mode_d    = MODE_IDLE;
			len_d     = '0;
		end else begin
			case (mode_q)
				MODE_WORD: begin
					if (c_alnum) begin
						add = 1'b1;
					end else begin
						restart = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(c)) begin
						add = 1'b1;
					end else begin
						restart = 1'b1;
					end
				end
				MODE_SLASH: begin
					if (c == CH_SLASH) begin
						mode_d = MODE_COMMENT;
					end else begin
						restart = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (c == CH_NEWLINE) begin
						use_flush = 1'b1;
						mode_d    = MODE_IDLE;
						len_d     = '0;
					end
				end
				default: begin
					restart = 1'b1;
				end
			endcase
		end
		if (add) begin
			len_d = len_grow;
		end
		if (restart) begin
			use_flush = flush_vld;
			use_start = start_vld;
			mode_d    = start_mode;
			len_d     = c_alnum ? LW'(1) : '0;
		end
	end

	// Character store: the first few characters of a word, for keyword match.
	assign chars_idx = restart ? '0 : len_q;
	assign chars_we  = accept && ((restart && c_alnum) || (add && int'(len_q) < KEYWORD_CHARS));

	always_ff @(posedge clk) begin
		for (int k = 0; k < KEYWORD_CHARS; k++) begin
			if (chars_we && int'(chars_idx) == k) begin
				chars_q[k] <= c;
			end
		end
	end

	// Scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			len_q  <= len_d;
		end
	end

	// Record for the queue.
	assign push_req.push     = accept && (use_flush || use_start);
	assign push_req.rec.two  = use_flush && use_start;
	assign push_req.rec.tok0 = use_flush ? flush_tok : start_tok;
	assign push_req.rec.tok1 = start_tok;

endmodule

@@ design/cstc_queue.sv @@
// Short queue of token records between the scanner and the output stage.
module cstc_queue import cstc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  push_req_t push_req,
	input  logic      pop,
	output logic      full,
	output logic      head_vld,
	output tok_rec_t  head
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	tok_rec_t      entries_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign head_vld = (count_q != '0);
	assign head     = entries_q[rd_ptr_q];
	assign do_push  = push_req.push && !full;
	assign do_pop   = pop && head_vld;

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_req.rec;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ design/cstc_back.sv @@
// Output stage: holds one record and sends its one or two token words.
module cstc_back import cstc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_vld,
	input  tok_rec_t      head,
	output logic          pop,
	cstc_token_if.source  token_chan
);

	tok_rec_t rec_q;
	token_t   tok;
	logic     hold_q, phase_q, last, fire;

	assign last = !rec_q.two || phase_q;
	assign fire = hold_q && token_chan.ready;
	assign pop  = head_vld && (!hold_q || (fire && last));

	// Occupancy and which half of a two-token record is on the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (pop) begin
			hold_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (fire) begin
			if (last) begin
				hold_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= head;
		end
	end

	// Output word.
	assign tok                      = phase_q ? rec_q.tok1 : rec_q.tok0;
	assign token_chan.valid         = hold_q;
	assign token_chan.token_kind    = tok.kind;
	assign token_chan.symbol        = tok.symbol;
	assign token_chan.token_length  = tok.length;
	assign token_chan.keyword_index = tok.kw_index;
	assign token_chan.last_result   = last;

endmodule

@@ design/c_subset_token_classifier.sv @@
// Top level of the C-subset token classifier.
// The block takes one character word per clock cycle without pause as long as the
// four-entry record queue has room; a character that ends a pending word, number or
// slash and is itself a token produces two output words, sent one after the other
// by the output stage, so the input stalls only when such pairs, or a stalled
// output, fill the queue. A token passes the record queue and the output stage's
// record register before it reaches the output. The keyword compare runs over all
// ten keywords in parallel in the cycle the ending character is taken. last_result
// marks the final word a character caused; end_of_input flushes any pending token.
module c_subset_token_classifier import cstc_pkg::*; #(
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
	parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	cstc_char_if.sink    char_chan,
	cstc_token_if.source token_chan
);

	push_req_t push_req;
	tok_rec_t  head;
	logic      q_full, head_vld, pop;

	// Scanner and classifier.
	cstc_front #(
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN),
		.KEYWORD_CHARS (KEYWORD_CHARS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_chan (char_chan),
		.q_full    (q_full),
		.push_req  (push_req)
	);

	// Record queue.
	cstc_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_req (push_req),
		.pop      (pop),
		.full     (q_full),
		.head_vld (head_vld),
		.head     (head)
	);

	// Output stage.
	cstc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_vld   (head_vld),
		.head       (head),
		.pop        (pop),
		.token_chan (token_chan)
	);

endmodule

@@ design/cstc_checker.sv @@
// Port-level checks on the token output of the classifier, bound to the top level.
module cstc_checker import cstc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] token_kind,
	input logic [7:0] symbol,
	input logic [5:0] token_length,
	input logic [3:0] keyword_index,
	input logic       last_result
);

	// A stalled token word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({token_kind, symbol, token_length, keyword_index, last_result}))
		else $error("token word changed while stalled");

	// Only keywords carry a keyword index.
	a_kw_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((token_kind == KIND_KEYWORD) == (keyword_index != NO_KEYWORD)))
		else $error("keyword index does not match token kind");

	// Word-like tokens and comments carry no symbol.
	a_no_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == KIND_KEYWORD || token_kind == KIND_IDENT ||
		token_kind == KIND_NUMBER || token_kind == KIND_COMMENT) |-> symbol == 8'h00)
		else $error("symbol set on a word or comment token");

	// Single-character tokens and comments carry no length.
	a_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == KIND_OPERATOR || token_kind == KIND_SEPARATOR ||
		token_kind == KIND_UNKNOWN || token_kind == KIND_COMMENT) |-> token_length == 6'd0)
		else $error("length set on a non-word token");

	// The first of two words from one character is a word, a number or a lone slash.
	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_result |-> (token_kind == KIND_KEYWORD ||
		token_kind == KIND_IDENT || token_kind == KIND_NUMBER ||
		(token_kind == KIND_OPERATOR && symbol == CH_SLASH)))
		else $error("unexpected token ahead of a second result");

endmodule

bind c_subset_token_classifier cstc_checker u_cstc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (token_chan.valid),
	.out_ready     (token_chan.ready),
	.token_kind    (token_chan.token_kind),
	.symbol        (token_chan.symbol),
	.token_length  (token_chan.token_length),
	.keyword_index (token_chan.keyword_index),
	.last_result   (token_chan.last_result)
);

@@ test/c_subset_token_classifier_tb.sv @@
// Self-checking testbench for the C-subset token classifier: directed and random bytes vs a lexer model.
module c_subset_token_classifier_tb;
	import cstc_pkg::*;

	localparam int MAX_LEN      = MAX_TOKEN_LEN_DEF;
	localparam int KW_CHARS     = KEYWORD_CHARS_DEF;
	localparam int DIRECTED_N   = 25;
	localparam int RANDOM_N     = 1300;
	localparam int HOLD_CYCLES  = 150;
	localparam int HOLD_AFTER   = 300;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;

	// One character word as the sender offers it.
	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
	} char_word_t;

	// One token word as the block should send it.
	typedef struct {
		token_kind_t kind;
		logic [7:0]  symbol;
		logic [5:0]  length;
		logic [3:0]  kw_index;
		logic        last;
	} token_exp_t;

	// Receiver behavior patterns.
	typedef enum logic [1:0] {
		SINK_FULL,
		SINK_HALF,
		SINK_SPARSE,
		SINK_MOSTLY
	} sink_style_t;

	logic clk;
	logic arst_n;
	logic hold_off;

	cstc_char_if  char_chan ();
	cstc_token_if token_chan ();

	c_subset_token_classifier #(
		.MAX_TOKEN_LEN(MAX_LEN),
		.KEYWORD_CHARS(KW_CHARS),
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_chan(char_chan),
		.token_chan(token_chan)
	);

	char_word_t char_queue [$];
	token_exp_t tokens_due [$];
	token_exp_t step_tokens [$];

	// Lexer state kept by the testbench.
	scan_mode_t lex_mode;
	logic [7:0] lex_chars [KW_CHARS];
	int         lex_len;

	int chars_taken;
	int tokens_checked;
	int mismatches;
	int pair_steps;
	int kind_seen [7];
	int stall_run;
	int longest_stall;

	// Character classes.
	function automatic bit letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit numeral(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit blank(logic [7:0] c);
		return c == " " || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic void add_token(token_kind_t k, logic [7:0] s, logic [5:0] l,
		logic [3:0] i);
		token_exp_t t;
		t.kind = k;
		t.symbol = s;
		t.length = l;
		t.kw_index = i;
		t.last = 1'b0;
		step_tokens.push_back(t);
	endfunction

	// Finds the keyword the current word spells, if any.
	function automatic logic [3:0] keyword_lookup();
		bit hit;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (lex_len == KW_LEN[i] && KW_LEN[i] <= KW_CHARS) begin
				hit = 1'b1;
				for (int j = 0; j < KW_LEN[i]; j++)
					if (lex_chars[j] != KW_TEXT[i][j])
						hit = 1'b0;
				if (hit)
					return 4'(i);
			end
		end
		return NO_KEYWORD;
	endfunction

	// Emits whatever token is pending and goes back to idle.
	function automatic void close_token();
		logic [3:0] kw;
		case (lex_mode)
			MODE_WORD: begin
				kw = keyword_lookup();
				if (kw == NO_KEYWORD)
					add_token(KIND_IDENT, 8'h00, lex_len[5:0], NO_KEYWORD);
				else
					add_token(KIND_KEYWORD, 8'h00, lex_len[5:0], kw);
			end
			MODE_NUMBER:  add_token(KIND_NUMBER, 8'h00, lex_len[5:0], NO_KEYWORD);
			MODE_SLASH:   add_token(KIND_OPERATOR, CH_SLASH, 6'd0, NO_KEYWORD);
			MODE_COMMENT: add_token(KIND_COMMENT, 8'h00, 6'd0, NO_KEYWORD);
			default: ;
		endcase
		lex_mode = MODE_IDLE;
		lex_len = 0;
	endfunction

	function automatic void append_char(logic [7:0] c);
		if (lex_len < KW_CHARS)
			lex_chars[lex_len] = c;
		if (lex_len < MAX_LEN)
			lex_len++;
	endfunction

	// Classifies a byte as seen from idle.
	function automatic void open_token(logic [7:0] c);
		if (blank(c))
			return;
		if (letter(c) || numeral(c)) begin
			lex_mode = letter(c) ? MODE_WORD : MODE_NUMBER;
			lex_len = 0;
			append_char(c);
		end else if (c == CH_SLASH) begin
			lex_mode = MODE_SLASH;
		end else if (c == "+" || c == "-" || c == "*" || c == "=" || c == "<" || c == ">") begin
			add_token(KIND_OPERATOR, c, 6'd0, NO_KEYWORD);
		end else if (c == ";" || c == "," || c == "(" || c == ")" || c == "{" || c == "}") begin
			add_token(KIND_SEPARATOR, c, 6'd0, NO_KEYWORD);
		end else begin
			add_token(KIND_UNKNOWN, c, 6'd0, NO_KEYWORD);
		end
	endfunction

	// Advances the lexer by one accepted word and queues the tokens it causes.
	function automatic void lex_step(logic [7:0] c, logic eoi);
		step_tokens.delete();
		if (eoi) begin
			close_token();
		end else begin
			case (lex_mode)
				MODE_WORD: begin
					if (letter(c) || numeral(c))
						append_char(c);
					else begin
						close_token();
						open_token(c);
					end
				end
				MODE_NUMBER: begin
					if (numeral(c))
						append_char(c);
					else begin
						close_token();
						open_token(c);
					end
				end
				MODE_SLASH: begin
					if (c == CH_SLASH)
						lex_mode = MODE_COMMENT;
					else begin
						close_token();
						open_token(c);
					end
				end
				MODE_COMMENT: begin
					if (c == CH_NEWLINE)
						close_token();
				end
				default: begin
					lex_mode = MODE_IDLE;
					open_token(c);
				end
			endcase
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		if (step_tokens.size() == 2)
			pair_steps++;
		foreach (step_tokens[i])
			tokens_due.push_back(step_tokens[i]);
	endfunction

	// Stimulus helpers.
	function automatic void add_byte(logic [7:0] c);
		char_queue.push_back('{ch: c, eoi: 1'b0});
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic void add_eoi();
		char_queue.push_back('{ch: 8'($urandom_range(0, 255)), eoi: 1'b1});
	endfunction

	function automatic logic [7:0] rand_letter();
		int idx;
		idx = $urandom_range(0, 51);
		return (idx < 26) ? 8'("a" + idx) : 8'("A" + idx - 26);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_blank();
		int idx;
		idx = $urandom_range(0, 5);
		return (idx == 0) ? " " : 8'(8'h09 + idx - 1);
	endfunction

	function automatic int rand_span(int short_max);
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(MAX_LEN - 3, MAX_LEN + 12);
		return $urandom_range(1, short_max);
	endfunction

	// Appends one random lexical element, mostly well formed.
	function automatic void add_random_chunk();
		string ops;
		string seps;
		int pick;
		int n;
		int k;
		logic [7:0] b;
		ops = "+-*=<>";
		seps = ";,(){}";
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			k = $urandom_range(0, KW_COUNT - 1);
			for (int j = 0; j < KW_LEN[k]; j++)
				add_byte(KW_TEXT[k][j]);
			if ($urandom_range(0, 4) == 0)
				add_byte($urandom_range(0, 1) ? rand_letter() : rand_digit());
		end else if (pick < 36) begin
			n = rand_span(9);
			add_byte(rand_letter());
			for (int j = 1; j < n; j++)
				add_byte($urandom_range(0, 2) ? rand_letter() : rand_digit());
		end else if (pick < 50) begin
			n = rand_span(8);
			for (int j = 0; j < n; j++)
				add_byte(rand_digit());
		end else if (pick < 58) begin
			add_byte(ops[$urandom_range(0, 5)]);
		end else if (pick < 66) begin
			add_byte(seps[$urandom_range(0, 5)]);
		end else if (pick < 72) begin
			add_text("//");
			n = $urandom_range(0, 10);
			for (int j = 0; j < n; j++) begin
				do b = 8'($urandom_range(0, 255)); while (b == CH_NEWLINE);
				add_byte(b);
			end
			if ($urandom_range(0, 9) == 0)
				add_eoi();
			else
				add_byte(CH_NEWLINE);
		end else if (pick < 76) begin
			add_byte(CH_SLASH);
		end else if (pick < 84) begin
			add_byte(8'($urandom_range(0, 255)));
		end else if (pick < 88) begin
			add_eoi();
		end else begin
			n = $urandom_range(1, 3);
			for (int j = 0; j < n; j++)
				add_byte(rand_blank());
		end
		if ($urandom_range(0, 1) == 0)
			add_byte(rand_blank());
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sender: offers queued words in bursts separated by random gaps.
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_chan.valid <= 1'b0;
			char_chan.char_in <= 8'h00;
			char_chan.end_of_input <= 1'b0;
			burst_left = $urandom_range(1, 40);
			gap_left = 0;
		end else if (!char_chan.valid || char_chan.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				char_chan.valid <= 1'b0;
			end else if (char_queue.size() > 0) begin
				char_chan.valid <= 1'b1;
				char_chan.char_in <= char_queue[0].ch;
				char_chan.end_of_input <= char_queue[0].eoi;
				char_queue.pop_front();
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				char_chan.valid <= 1'b0;
			end
		end
	end

	// Receiver: ready follows a random pattern, picked anew when pattern_left runs out.
	sink_style_t sink_style;
	int pattern_left;
	int sink_tick;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_chan.ready <= 1'b0;
			pattern_left = 0;
			sink_tick = 0;
			sink_style = SINK_FULL;
		end else begin
			if (pattern_left == 0) begin
				sink_style = sink_style_t'($urandom_range(0, 3));
				pattern_left = 64;
			end
			pattern_left--;
			sink_tick++;
			case (sink_style)
				SINK_FULL:   token_chan.ready <= !hold_off;
				SINK_HALF:   token_chan.ready <= !hold_off && ($urandom_range(0, 1) == 1);
				SINK_SPARSE: token_chan.ready <= !hold_off && (sink_tick % 4 == 0);
				default:     token_chan.ready <= !hold_off && ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// One long output hold while the sender keeps offering, to back the block up.
	initial begin : long_hold
		hold_off = 1'b0;
		wait (chars_taken >= HOLD_AFTER);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Monitor: predicts on every accepted character and checks every accepted token.
	always @(posedge clk) begin : monitor
		token_exp_t due;
		if (arst_n) begin
			if (char_chan.valid && !char_chan.ready)
				stall_run++;
			else
				stall_run = 0;
			if (stall_run > longest_stall)
				longest_stall = stall_run;

			if (char_chan.valid && char_chan.ready) begin
				lex_step(char_chan.char_in, char_chan.end_of_input);
				chars_taken++;
			end

			if (token_chan.valid && token_chan.ready) begin
				if (tokens_due.size() == 0) begin
					if (mismatches < 10)
						$display("token %0d: unexpected word kind=%0d sym=%02h len=%0d kw=%0d last=%0b",
							tokens_checked, token_chan.token_kind, token_chan.symbol,
							token_chan.token_length, token_chan.keyword_index,
							token_chan.last_result);
					mismatches++;
				end else begin
					due = tokens_due.pop_front();
					kind_seen[due.kind]++;
					if (token_chan.token_kind !== due.kind || token_chan.symbol !== due.symbol ||
						token_chan.token_length !== due.length ||
						token_chan.keyword_index !== due.kw_index ||
						token_chan.last_result !== due.last) begin
						if (mismatches < 10)
							$display("token %0d: expected kind=%0d sym=%02h len=%0d kw=%0d last=%0b, got kind=%0d sym=%02h len=%0d kw=%0d last=%0b",
								tokens_checked, due.kind, due.symbol, due.length, due.kw_index,
								due.last, token_chan.token_kind, token_chan.symbol,
								token_chan.token_length, token_chan.keyword_index,
								token_chan.last_result);
						mismatches++;
					end
				end
				tokens_checked++;
			end
		end
	end

	// Watchdog: ends the run if neither side moves a word for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((char_chan.valid && char_chan.ready) || (token_chan.valid && token_chan.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("no handshake for %0d cycles, %0d tokens still due", STALL_LIMIT,
			tokens_due.size());
		$display("c_subset_token_classifier: mismatch");
		$finish;
	end

	// Main sequence: stimulus, reset, drain, verdict.
	initial begin
		arst_n = 1'b0;
		char_chan.valid = 1'b0;
		char_chan.char_in = 8'h00;
		char_chan.end_of_input = 1'b0;
		token_chan.ready = 1'b0;
		lex_mode = MODE_IDLE;
		lex_len = 0;
		chars_taken = 0;
		tokens_checked = 0;
		mismatches = 0;
		pair_steps = 0;
		stall_run = 0;
		longest_stall = 0;
		foreach (kind_seen[i])
			kind_seen[i] = 0;

		// Directed: keyword, word ended by a separator, digits running into a letter,
		// lone slash before an operator, a comment, byte extremes as unknowns,
		// end of input after a slash, inside a comment and while idle.
		add_text("int ");
		add_text("v1(");
		add_text("42x}");
		add_text("/*");
		add_text("//");
		add_byte(8'hFF);
		add_byte(CH_NEWLINE);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(CH_SLASH);
		add_eoi();
		add_text("//");
		add_eoi();
		add_eoi();

		while (char_queue.size() < DIRECTED_N + RANDOM_N)
			add_random_chunk();
		add_eoi();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (char_queue.size() > 0 || char_chan.valid)
			@(posedge clk);
		while (tokens_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d characters, %0d tokens (kw %0d id %0d num %0d op %0d sep %0d unk %0d cmt %0d)",
			chars_taken, tokens_checked, kind_seen[KIND_KEYWORD], kind_seen[KIND_IDENT],
			kind_seen[KIND_NUMBER], kind_seen[KIND_OPERATOR], kind_seen[KIND_SEPARATOR],
			kind_seen[KIND_UNKNOWN], kind_seen[KIND_COMMENT]);
		$display("%0d characters gave two tokens; longest input stall %0d cycles; %0d mismatches",
			pair_steps, longest_stall, mismatches);
		if (mismatches == 0)
			$display("c_subset_token_classifier: match");
		else
			$display("c_subset_token_classifier: mismatch");
		$finish;
	end

endmodule
